@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the compositor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define RLPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RLPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlpc_pkg
// Shared types and constants of the rounded layer pixel compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpc_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_WIN_X       = 3'd0;
  localparam logic [2:0] REG_WIN_Y       = 3'd1;
  localparam logic [2:0] REG_WIN_WIDTH   = 3'd2;
  localparam logic [2:0] REG_WIN_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_BACKGROUND  = 3'd4;
  localparam logic [2:0] REG_LAYER_COUNT = 3'd5;

  localparam int SQRT_BITS = 9;
  localparam int LIM_W     = 2 * SQRT_BITS;

  typedef struct packed {
    logic signed [9:0] left;
    logic signed [9:0] top;
    logic [9:0]        w;
    logic [9:0]        h;
    logic [7:0]        radius;
    logic [10:0]       stride;
  } rlpc_layer_t;

  typedef struct packed {
    logic              active;
    logic              corner;
    logic [7:0]        r;
    logic [8:0]        d;
    logic signed [9:0] left;
    logic [9:0]        w;
    logic [9:0]        sy;
    logic [10:0]       stride;
  } rlpc_lane_t;

  typedef struct packed {
    logic [8:0]  win_x;
    logic [8:0]  win_y;
    logic [8:0]  win_width;
    logic [8:0]  win_height;
    logic [15:0] background;
    logic [2:0]  layer_count;
  } rlpc_cfg_t;

endpackage

`default_nettype wire

@@ design/rlpc_front.sv @@
// ----------------------------------------------------------------------------
// rlpc_front
// Layer table and query classification: per layer row test, clamped radius,
// edge distance and corner term for each accepted query.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpc_front #(
  parameter int LAYERS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     accept,
  input  wire logic                     in_opcode,
  input  wire logic [1:0]               in_layer_slot,
  input  wire logic signed [9:0]        in_layer_left,
  input  wire logic signed [9:0]        in_layer_top,
  input  wire logic [9:0]               in_layer_w,
  input  wire logic [9:0]               in_layer_h,
  input  wire logic [7:0]               in_corner_radius,
  input  wire logic [10:0]              in_row_stride,
  input  wire logic [8:0]               in_pixel_col,
  input  wire logic [8:0]               in_pixel_row,
  input  wire rlpc_pkg::rlpc_cfg_t      cfg,
  output logic                          push,
  output logic [9:0]                    q_x,
  output rlpc_pkg::rlpc_lane_t [LAYERS-1:0] q_lanes
);
  import rlpc_pkg::*;

  rlpc_layer_t table_r [LAYERS];
  logic [9:0]  y;
  logic        inwin;

  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_LOAD) begin
      for (int i = 0; i < LAYERS; i++) begin
        if ({29'd0, in_layer_slot} == 31'(i)) begin
          table_r[i] <= '{left: in_layer_left, top: in_layer_top, w: in_layer_w,
                          h: in_layer_h, radius: in_corner_radius,
                          stride: in_row_stride};
        end
      end
    end
  end

  assign push  = accept && in_opcode == OP_QUERY;
  assign q_x   = {1'b0, cfg.win_x} + {1'b0, in_pixel_col};
  assign y     = {1'b0, cfg.win_y} + {1'b0, in_pixel_row};
  assign inwin = in_pixel_col < cfg.win_width && in_pixel_row < cfg.win_height;

  for (genvar g = 0; g < LAYERS; g++) begin : g_lane
    logic signed [11:0] sy_full;
    logic               rowok;
    logic [9:0]         sy;
    logic [9:0]         hm;
    logic [9:0]         e;
    logic [9:0]         mwh;
    logic [7:0]         r;
    logic               in_use;

    assign sy_full = $signed({2'b00, y}) - 12'(table_r[g].top);
    assign rowok   = !sy_full[11] && sy_full[10:0] < {1'b0, table_r[g].h};
    assign sy      = sy_full[9:0];
    assign hm      = table_r[g].h - 10'd1 - sy;
    assign e       = (sy < hm) ? sy : hm;
    assign mwh     = ((table_r[g].w < table_r[g].h) ? table_r[g].w : table_r[g].h) >> 1;
    assign r       = ({2'b00, table_r[g].radius} < mwh) ? table_r[g].radius : mwh[7:0];
    assign in_use  = 4'(g) < {1'b0, cfg.layer_count};

    assign q_lanes[g].active = inwin && rowok && in_use;
    assign q_lanes[g].corner = r != 8'd0 && e < {2'b00, r};
    assign q_lanes[g].r      = r;
    assign q_lanes[g].d      = {r, 1'b0} - {e[7:0], 1'b0} - 9'd1;
    assign q_lanes[g].left   = table_r[g].left;
    assign q_lanes[g].w      = table_r[g].w;
    assign q_lanes[g].sy     = sy;
    assign q_lanes[g].stride = table_r[g].stride;
  end

endmodule

`default_nettype wire

@@ design/rlpc_queue.sv @@
// ----------------------------------------------------------------------------
// rlpc_queue
// Short queue of classified queries between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpc_queue #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty,
  output logic              full
);
  import rlpc_pkg::*;

  localparam int DEPTH = 4;

  logic [W-1:0] mem_r [DEPTH];
  logic [1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [2:0]   count_r, count_nxt;

  assign empty = count_r == 3'd0;
  assign full  = count_r == 3'(DEPTH);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`include "assert_macros.svh"

  `RLPC_ASSERT(a_no_pop_empty, !(pop && empty), "Queue popped while empty.")
  `RLPC_ASSERT(a_no_push_full, !(push && full), "Queue pushed while full.")
  `RLPC_ASSERT(a_count_ptrs, count_r == 3'(DEPTH) || 2'(count_r) == wr_ptr_r - rd_ptr_r, "Queue count disagrees with pointers.")
  `RLPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> count_r == 3'd0, "Queue not empty after reset.")

endmodule

`default_nettype wire

@@ design/rlpc_back.sv @@
// ----------------------------------------------------------------------------
// rlpc_back
// Per layer corner inset by a pipelined integer square root, span test,
// topmost layer selection, source offset and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpc_back #(
  parameter int LAYERS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic [9:0]                   q_x,
  input  wire rlpc_pkg::rlpc_lane_t [LAYERS-1:0] q_lanes,
  input  wire rlpc_pkg::rlpc_cfg_t          cfg,
  output logic                              adv,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              out_covered,
  output logic [1:0]                        out_layer_hit,
  output logic [19:0]                       out_source_offset,
  output logic [15:0]                       out_color
);
  import rlpc_pkg::*;

  typedef struct packed {
    logic                 active;
    logic                 corner;
    logic [7:0]           r;
    logic [LIM_W-1:0]     lim;
    logic [SQRT_BITS-1:0] root;
    logic signed [9:0]    left;
    logic [9:0]           w;
    logic [9:0]           sy;
    logic [10:0]          stride;
  } rlpc_bk_t;

  logic [SQRT_BITS:0] vld_r;
  logic [9:0]         x_r   [SQRT_BITS+1];
  rlpc_bk_t           bk_r  [SQRT_BITS+1][LAYERS];
  rlpc_bk_t           bk_nxt[SQRT_BITS+1][LAYERS];

  logic        sel_vld_r, sel_cov_r, sel_cov_nxt;
  logic [1:0]  sel_idx_r, sel_idx_nxt;
  logic [9:0]  sel_sy_r, sel_sy_nxt;
  logic [10:0] sel_stride_r, sel_stride_nxt;
  logic [9:0]  sel_xoff_r, sel_xoff_nxt;

  logic        out_valid_r;
  logic        out_covered_r;
  logic [1:0]  out_layer_hit_r;
  logic [19:0] out_source_offset_r, out_source_offset_nxt;
  logic [15:0] out_color_r;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    logic [15:0]          rsq;
    logic [LIM_W-1:0]     dsq;
    logic [SQRT_BITS-1:0] cand;
    for (int l = 0; l < LAYERS; l++) begin
      rsq = 16'(q_lanes[l].r) * 16'(q_lanes[l].r);
      dsq = LIM_W'(q_lanes[l].d) * LIM_W'(q_lanes[l].d);
      bk_nxt[0][l].active = q_lanes[l].active;
      bk_nxt[0][l].corner = q_lanes[l].corner;
      bk_nxt[0][l].r      = q_lanes[l].r;
      bk_nxt[0][l].lim    = {rsq, 2'b00} - dsq;
      bk_nxt[0][l].root   = '0;
      bk_nxt[0][l].left   = q_lanes[l].left;
      bk_nxt[0][l].w      = q_lanes[l].w;
      bk_nxt[0][l].sy     = q_lanes[l].sy;
      bk_nxt[0][l].stride = q_lanes[l].stride;
    end
    for (int s = 1; s <= SQRT_BITS; s++) begin
      for (int l = 0; l < LAYERS; l++) begin
        bk_nxt[s][l] = bk_r[s-1][l];
        cand = bk_r[s-1][l].root | (SQRT_BITS'(1) << (SQRT_BITS - s));
        if (LIM_W'(cand) * LIM_W'(cand) <= bk_r[s-1][l].lim) begin
          bk_nxt[s][l].root = cand;
        end
      end
    end
  end

  always_comb begin
    logic [7:0]         inset;
    logic signed [11:0] xs, lo_l, hi_l, wx, wend;
    logic [11:0]        xoff;
    sel_cov_nxt    = 1'b0;
    sel_idx_nxt    = '0;
    sel_sy_nxt     = '0;
    sel_stride_nxt = '0;
    sel_xoff_nxt   = '0;
    xs   = $signed({2'b00, x_r[SQRT_BITS]});
    wx   = $signed({3'b000, cfg.win_x});
    wend = $signed({3'b000, cfg.win_x}) + $signed({3'b000, cfg.win_width});
    for (int l = 0; l < LAYERS; l++) begin
      inset = bk_r[SQRT_BITS][l].corner ?
              bk_r[SQRT_BITS][l].r - 8'd1 - 8'((bk_r[SQRT_BITS][l].root - 9'd1) >> 1) : 8'd0;
      lo_l = 12'(bk_r[SQRT_BITS][l].left) + $signed({4'b0000, inset});
      hi_l = 12'(bk_r[SQRT_BITS][l].left) + $signed({2'b00, bk_r[SQRT_BITS][l].w})
             - $signed({4'b0000, inset});
      xoff = 12'(xs - 12'(bk_r[SQRT_BITS][l].left));
      if (bk_r[SQRT_BITS][l].active && xs >= wx && xs >= lo_l && xs < wend && xs < hi_l) begin
        sel_cov_nxt    = 1'b1;
        sel_idx_nxt    = 2'(l);
        sel_sy_nxt     = bk_r[SQRT_BITS][l].sy;
        sel_stride_nxt = bk_r[SQRT_BITS][l].stride;
        sel_xoff_nxt   = xoff[9:0];
      end
    end
  end

  assign out_source_offset_nxt = 20'(21'(sel_sy_r) * 21'(sel_stride_r)) +
                                 {9'd0, sel_xoff_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      sel_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[SQRT_BITS-1:0], take};
      sel_vld_r   <= vld_r[SQRT_BITS];
      out_valid_r <= sel_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= q_x;
      for (int s = 1; s <= SQRT_BITS; s++) begin
        x_r[s] <= x_r[s-1];
      end
      for (int s = 0; s <= SQRT_BITS; s++) begin
        for (int l = 0; l < LAYERS; l++) begin
          bk_r[s][l] <= bk_nxt[s][l];
        end
      end
      sel_cov_r           <= sel_cov_nxt;
      sel_idx_r           <= sel_idx_nxt;
      sel_sy_r            <= sel_sy_nxt;
      sel_stride_r        <= sel_stride_nxt;
      sel_xoff_r          <= sel_xoff_nxt;
      out_covered_r       <= sel_cov_r;
      out_layer_hit_r     <= sel_cov_r ? sel_idx_r : 2'd0;
      out_source_offset_r <= sel_cov_r ? out_source_offset_nxt : 20'd0;
      out_color_r         <= sel_cov_r ? 16'd0 : cfg.background;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_covered       = out_covered_r;
  assign out_layer_hit     = out_layer_hit_r;
  assign out_source_offset = out_source_offset_r;
  assign out_color         = out_color_r;

`include "assert_macros.svh"

  `RLPC_ASSERT(a_cov_color, out_valid_r && out_covered_r |-> out_color_r == 16'd0, "Covered pixel carries a color.")
  `RLPC_ASSERT(a_bg_fields, out_valid_r && !out_covered_r |-> out_layer_hit_r == 2'd0 && out_source_offset_r == 20'd0, "Background pixel carries layer fields.")
  `RLPC_ASSERT(a_hold_pipe, !adv |=> $stable(vld_r) && $stable(sel_vld_r), "Pipeline moved while the result was stalled.")

endmodule

`default_nettype wire

@@ design/rounded_layer_pixel_compositor.sv @@
// ----------------------------------------------------------------------------
// rounded_layer_pixel_compositor
// Per pixel layer decision for rounded rectangle layers.
// ----------------------------------------------------------------------------
// One beat is accepted per clock while the queue is not full. A load beat
// writes the layer table at once and gives no result. A query beat passes
// through the queue, a stage that forms the square root operand, the nine
// stage integer square root that each layer lane runs to find its corner
// inset, and the span selection and the offset multiply stages before its
// result appears. Results leave in query order, and a four entry queue lets
// the input side keep taking beats while a result waits, until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_layer_pixel_compositor #(
  parameter int LAYERS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic [1:0]         in_layer_slot,
  input  wire logic signed [9:0]  in_layer_left,
  input  wire logic signed [9:0]  in_layer_top,
  input  wire logic [9:0]         in_layer_w,
  input  wire logic [9:0]         in_layer_h,
  input  wire logic [7:0]         in_corner_radius,
  input  wire logic [10:0]        in_row_stride,
  input  wire logic [8:0]         in_pixel_col,
  input  wire logic [8:0]         in_pixel_row,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_covered,
  output logic [1:0]              out_layer_hit,
  output logic [19:0]             out_source_offset,
  output logic [15:0]             out_color,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rlpc_pkg::*;

  localparam int QW = 10 + LAYERS * $bits(rlpc_lane_t);

  rlpc_cfg_t  cfg_r;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic                          accept;
  logic                          push;
  logic [9:0]                    f_x;
  rlpc_lane_t [LAYERS-1:0]       f_lanes;
  logic [QW-1:0]                 q_rdata;
  logic                          q_empty;
  logic                          q_full;
  logic                          adv;
  logic                          pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{win_x: 9'd0, win_y: 9'd0, win_width: 9'd360, win_height: 9'd360,
                 background: 16'd0, layer_count: 3'd1};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIN_X:       cfg_r.win_x       <= pwdata[8:0];
        REG_WIN_Y:       cfg_r.win_y       <= pwdata[8:0];
        REG_WIN_WIDTH:   cfg_r.win_width   <= pwdata[8:0];
        REG_WIN_HEIGHT:  cfg_r.win_height  <= pwdata[8:0];
        REG_BACKGROUND:  cfg_r.background  <= pwdata[15:0];
        REG_LAYER_COUNT: cfg_r.layer_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIN_X:       prdata = {23'd0, cfg_r.win_x};
      REG_WIN_Y:       prdata = {23'd0, cfg_r.win_y};
      REG_WIN_WIDTH:   prdata = {23'd0, cfg_r.win_width};
      REG_WIN_HEIGHT:  prdata = {23'd0, cfg_r.win_height};
      REG_BACKGROUND:  prdata = {16'd0, cfg_r.background};
      REG_LAYER_COUNT: prdata = {29'd0, cfg_r.layer_count};
      default:         prdata = 32'd0;
    endcase
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign pop      = adv && !q_empty;

  rlpc_front #(.LAYERS(LAYERS)) u_front (
    .clk             (clk),
    .accept          (accept),
    .in_opcode       (in_opcode),
    .in_layer_slot   (in_layer_slot),
    .in_layer_left   (in_layer_left),
    .in_layer_top    (in_layer_top),
    .in_layer_w      (in_layer_w),
    .in_layer_h      (in_layer_h),
    .in_corner_radius(in_corner_radius),
    .in_row_stride   (in_row_stride),
    .in_pixel_col    (in_pixel_col),
    .in_pixel_row    (in_pixel_row),
    .cfg             (cfg_r),
    .push            (push),
    .q_x             (f_x),
    .q_lanes         (f_lanes)
  );

  rlpc_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_x, f_lanes}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  rlpc_back #(.LAYERS(LAYERS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (pop),
    .q_x              (q_rdata[QW-1 -: 10]),
    .q_lanes          (q_rdata[QW-11:0]),
    .cfg              (cfg_r),
    .adv              (adv),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_covered      (out_covered),
    .out_layer_hit    (out_layer_hit),
    .out_source_offset(out_source_offset),
    .out_color        (out_color)
  );

endmodule

`default_nettype wire
